// ===== hdl/mca_pkg.sv =====
package mca_pkg;

   localparam int CHANNELS_DEF = 16;
   localparam int GROUPS_DEF   = 4;
   localparam int CSR_DATA_W   = 4;
   localparam int CSR_INDEX_W  = 2;

   typedef enum logic [1:0] {
      CMD_CONFIG = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_RESET  = 2'd2,
      CMD_UPDATE = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEST_EN  = 2'd0,
      CSR_FLASH_EN = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MASTER,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [3:0]         channel;
      logic signed [31:0] value;
      logic signed [31:0] high_limit;
      logic               invert;
      logic               allow_test;
      logic               allow_flash;
      logic [1:0]         group;
      logic               lamp_test;
      logic               flash_phase;
      logic               sim_running;
      logic               drive_pins;
   } req_type;

   typedef struct packed {
      logic [15:0] channel_lamps;
      logic [3:0]  master_lamps;
      logic [15:0] channel_active;
      logic        pins_driven;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic               invert;
      logic               allow_test;
      logic               allow_flash;
   } chan_cfg_type;

   typedef struct packed {
      logic exec;
      logic step;
      logic finish;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_update;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== hdl/master_caution_annunciator.sv =====
// Master caution annunciator panel.
// Requests arrive on the req_ channel (valid/stall); each one is a configure,
// sample store, master reset or lamp update transaction and produces exactly
// one response on the rsp_ channel with the lamp state and active bits.
// Configure, sample and master reset take effect at acceptance; the controller
// then moves to the response state, loads the response into the output register
// once it is free, and returns to idle for the next request. An update walks the channel
// memories one entry per cycle through the registered read port, then passes
// through the drain and master lamp states before it loads its response in the
// response state and returns to idle.
// One request is worked on at a time: req_stall drops again once the response
// has been loaded into the output register, so a new request may be taken
// while that response still waits for the receiver.
// When rsp_stall is high the response register holds; a following request
// completes its work but waits before loading its response.
// The csr_ port writes the master test and flash enables; write only when idle.
// Synchronous reset clears all lamps, latches, acknowledges, enables and the
// per-entry valid bits, so every table reads as zero; no clearing pass.
module master_caution_annunciator import mca_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int GROUPS   = GROUPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   ctl_cmd_type      cmd;
   dp_status_type    status;
   logic [CH_AW-1:0] step_addr;

   mca_ctl #(.CHANNELS(CHANNELS)) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .step_addr (step_addr)
   );

   mca_dp #(.CHANNELS(CHANNELS), .GROUPS(GROUPS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .step_addr (step_addr),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== hdl/mca_ram.sv =====
module mca_ram import mca_pkg::*; #(
   parameter int WIDTH = 32,
   parameter int DEPTH = CHANNELS_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mca_ctl.sv =====
module mca_ctl import mca_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dp_status_type     status,
   output ctl_cmd_type       cmd,
   output logic [CH_AW-1:0]  step_addr
);

   ctl_state_type    state_ff, state_in;
   logic [CH_AW-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      step_addr = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.exec = 1'b1;
               cnt_in   = '0;
               state_in = status.is_update ? ST_WALK : ST_RESP;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (cnt_ff == CH_AW'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MASTER;
         end
         ST_MASTER: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/mca_dp.sv =====
module mca_dp import mca_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEF,
   parameter int GROUPS   = GROUPS_DEF,
   localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   input  ctl_cmd_type            cmd,
   input  logic [CH_AW-1:0]       step_addr,
   output dp_status_type          status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CFG_W = $bits(chan_cfg_type);

   logic [CSR_DATA_W-1:0] test_en_ff, flash_en_ff;

   logic [CHANNELS-1:0] cfg_vld_ff, cfg_vld_in;
   logic [CHANNELS-1:0] smp_vld_ff, smp_vld_in;
   logic [1:0]          group_ff [CHANNELS];
   logic [1:0]          group_in [CHANNELS];
   logic [CHANNELS-1:0] active_ff, active_in;
   logic [CHANNELS-1:0] ack_ff, ack_in;
   logic [GROUPS-1:0]   latch_ff, latch_in;
   logic [CHANNELS-1:0] lamp_chan_ff, lamp_chan_in;
   logic [GROUPS-1:0]   lamp_mst_ff, lamp_mst_in;

   logic upd_test_ff, upd_flash_ff, upd_run_ff, pins_ff;

   logic             proc_vld_ff;
   logic [CH_AW-1:0] proc_idx_ff;
   logic             rd_cfg_vld_ff, rd_smp_vld_ff;

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic             ch_ok;
   logic [CH_AW-1:0] ch_idx;
   logic             cfg_we, smp_we;
   chan_cfg_type     cfg_wr, cfg_rd_raw, cfg_cur;
   logic [31:0]      smp_rd_raw;
   logic signed [31:0] smp_cur;
   logic             in_range, act, lit;
   logic [GROUPS-1:0] mte, mfe;

   assign ch_ok  = 32'(req_data.channel) < CHANNELS;
   assign ch_idx = CH_AW'(req_data.channel);
   assign cfg_we = cmd.exec && (req_data.cmd == CMD_CONFIG) && ch_ok;
   assign smp_we = cmd.exec && (req_data.cmd == CMD_SAMPLE) && ch_ok;

   always_comb begin
      cfg_wr.low         = req_data.value;
      cfg_wr.high        = req_data.high_limit;
      cfg_wr.invert      = req_data.invert;
      cfg_wr.allow_test  = req_data.allow_test;
      cfg_wr.allow_flash = req_data.allow_flash;
   end

   mca_ram #(.WIDTH(CFG_W), .DEPTH(CHANNELS)) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_we),
      .wr_addr (ch_idx),
      .wr_data (cfg_wr),
      .rd_en   (cmd.step),
      .rd_addr (step_addr),
      .rd_data (cfg_rd_raw)
   );

   mca_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_smp_ram (
      .clock   (clock),
      .wr_en   (smp_we),
      .wr_addr (ch_idx),
      .wr_data (req_data.value),
      .rd_en   (cmd.step),
      .rd_addr (step_addr),
      .rd_data (smp_rd_raw)
   );

   // entries never written read as zero
   assign cfg_cur = rd_cfg_vld_ff ? cfg_rd_raw : '0;
   assign smp_cur = rd_smp_vld_ff ? $signed(smp_rd_raw) : 32'sd0;

   assign in_range = (cfg_cur.low <= smp_cur) && (smp_cur <= cfg_cur.high);
   assign act      = in_range ^ cfg_cur.invert;
   assign lit      = ((act || (cfg_cur.allow_test && upd_test_ff))
                      && !(cfg_cur.allow_flash && !upd_flash_ff)) && upd_run_ff;

   assign mte = GROUPS'(test_en_ff);
   assign mfe = GROUPS'(flash_en_ff);

   always_comb begin
      cfg_vld_in   = cfg_vld_ff;
      smp_vld_in   = smp_vld_ff;
      group_in     = group_ff;
      active_in    = active_ff;
      ack_in       = ack_ff;
      latch_in     = latch_ff;
      lamp_chan_in = lamp_chan_ff;
      lamp_mst_in  = lamp_mst_ff;

      if (cfg_we) begin
         cfg_vld_in[ch_idx] = 1'b1;
         group_in[ch_idx]   = req_data.group;
      end
      if (smp_we) begin
         smp_vld_in[ch_idx] = 1'b1;
      end
      if (cmd.exec && (req_data.cmd == CMD_RESET) && (32'(req_data.group) < GROUPS)) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (group_ff[i] == req_data.group) begin
               ack_in[i] = active_ff[i];
            end
         end
         for (int g = 0; g < GROUPS; g++) begin
            if (32'(req_data.group) == g) begin
               latch_in[g] = 1'b0;
            end
         end
      end

      // one channel per step, old active and ack bits
      if (proc_vld_ff) begin
         for (int g = 0; g < GROUPS; g++) begin
            if ((32'(group_ff[proc_idx_ff]) == g) && active_ff[proc_idx_ff]
                && !ack_ff[proc_idx_ff]) begin
               latch_in[g] = 1'b1;
            end
         end
         ack_in[proc_idx_ff]       = ack_ff[proc_idx_ff] & active_ff[proc_idx_ff];
         active_in[proc_idx_ff]    = act;
         lamp_chan_in[proc_idx_ff] = lit;
      end

      if (cmd.finish) begin
         lamp_mst_in = ((latch_ff | (mte & {GROUPS{upd_test_ff}}))
                        & ~(mfe & {GROUPS{~upd_flash_ff}})) & {GROUPS{upd_run_ff}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         test_en_ff   <= '0;
         flash_en_ff  <= '0;
         cfg_vld_ff   <= '0;
         smp_vld_ff   <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            group_ff[i] <= '0;
         end
         active_ff    <= '0;
         ack_ff       <= '0;
         latch_ff     <= '0;
         lamp_chan_ff <= '0;
         lamp_mst_ff  <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TEST_EN:  test_en_ff  <= csr_wdata;
               CSR_FLASH_EN: flash_en_ff <= csr_wdata;
               default: ;
            endcase
         end
         cfg_vld_ff   <= cfg_vld_in;
         smp_vld_ff   <= smp_vld_in;
         group_ff     <= group_in;
         active_ff    <= active_in;
         ack_ff       <= ack_in;
         latch_ff     <= latch_in;
         lamp_chan_ff <= lamp_chan_in;
         lamp_mst_ff  <= lamp_mst_in;
         proc_vld_ff  <= cmd.step;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= step_addr;
      if (cmd.step) begin
         rd_cfg_vld_ff <= cfg_vld_ff[step_addr];
         rd_smp_vld_ff <= smp_vld_ff[step_addr];
      end
      if (cmd.exec) begin
         upd_test_ff  <= req_data.lamp_test;
         upd_flash_ff <= req_data.flash_phase;
         upd_run_ff   <= req_data.sim_running;
         pins_ff      <= (req_data.cmd == CMD_UPDATE) && req_data.drive_pins;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.channel_lamps  <= 16'(lamp_chan_ff);
         rsp_data_ff.master_lamps   <= 4'(lamp_mst_ff);
         rsp_data_ff.channel_active <= 16'(active_ff);
         rsp_data_ff.pins_driven    <= pins_ff;
      end
   end

   assign status.is_update = (req_data.cmd == CMD_UPDATE);
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule
